// File: rtl/srmb_pkg.sv
// ----------------------------------------------------------------------------
// srmb_pkg: shared types and constants of the serial register map bridge
// Codes, queue entry layout and configuration bundle used by all modules but the RAM.
// ----------------------------------------------------------------------------
`default_nettype none
package srmb_pkg;

  localparam int unsigned MAX_DATA_LEN_DEF = 32;
  localparam int unsigned LEN_W            = 6;
  localparam int unsigned MAP_DEPTH        = 256;

  // Input item modes
  typedef enum logic [2:0] {
    MODE_RX   = 3'd0,
    MODE_TICK = 3'd1,
    MODE_REG  = 3'd2,
    MODE_REM  = 3'd3,
    MODE_RD   = 3'd4,
    MODE_WR   = 3'd5
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HDR_FIRST  = 3'd0,
    CFG_HDR_SECOND = 3'd1,
    CFG_READ_CODE  = 3'd2,
    CFG_RET_CODE   = 3'd3,
    CFG_WRITE_CODE = 3'd4,
    CFG_TIMEOUT    = 3'd5
  } cfg_idx_t;

  // Receive phases
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_BADHDR = 2'd3
  } phase_t;

  // Operations passed from front to back
  typedef enum logic [2:0] {
    OP_REG   = 3'd0,
    OP_REM   = 3'd1,
    OP_RD    = 3'd2,
    OP_WR    = 3'd3,
    OP_PKT_R = 3'd4,
    OP_PKT_W = 3'd5
  } op_t;

  // Back end states
  typedef enum logic [3:0] {
    B_IDLE, B_LEXE, B_HDR, B_DRD, B_DOUT, B_SUM, B_WRD, B_WEXE
  } bstate_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       addr;
    logic [LEN_W-1:0] len;
    logic [7:0]       value;
    logic [1:0]       acc;
  } op_entry_t;

  typedef struct packed {
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    logic [2:0]  read_code;
    logic [2:0]  ret_code;
    logic [2:0]  write_code;
    logic [15:0] timeout;
  } cfg_t;

  // Status from back to front
  typedef struct packed {
    logic pkt_done;
  } back_stat_t;

endpackage
`default_nettype wire

// File: rtl/srmb_ram.sv
// ----------------------------------------------------------------------------
// srmb_ram: generic single write port RAM with registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module srmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/srmb_fifo.sv
// ----------------------------------------------------------------------------
// srmb_fifo: two-entry operation queue between front and back
// Lets the receiver and the executor stall independently.
// ----------------------------------------------------------------------------
`default_nettype none
module srmb_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire srmb_pkg::op_entry_t din,
  input  wire logic                pop,
  output srmb_pkg::op_entry_t      dout,
  output logic                     empty,
  output logic                     full
);
  import srmb_pkg::*;

  op_entry_t  slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign dout  = slot[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/srmb_front.sv
// ----------------------------------------------------------------------------
// srmb_front: receive framer and item classifier
// Hunts for frames, checks header and checksum, buffers packet data and
// queues local and packet operations for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module srmb_front #(
  parameter int unsigned MAX_DATA_LEN = srmb_pkg::MAX_DATA_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire srmb_pkg::cfg_t             cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_mode,
  input  wire logic [7:0]                 in_byte,
  input  wire logic [7:0]                 in_addr,
  input  wire logic [1:0]                 in_acc,
  input  wire logic [7:0]                 in_value,
  output logic                            q_push,
  output srmb_pkg::op_entry_t             q_din,
  input  wire logic                       q_full,
  input  wire srmb_pkg::back_stat_t       bstat,
  input  wire logic [srmb_pkg::LEN_W-1:0] fd_idx,
  output logic [7:0]                      fd_byte
);
  import srmb_pkg::*;

  localparam int unsigned DAW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [7:0]       fcmd, faddr;
  logic [LEN_W-1:0] flen;
  logic [7:0]       fsum;
  logic [15:0]      elapsed, el_inc;
  logic [7:0]       fdata [MAX_DATA_LEN];
  logic [1:0]       pkt_cnt;
  logic             acc_item, is_read, take_data, hdr_ok, timed_out;
  logic             push_pkt;

  assign in_ready  = !q_full && (pkt_cnt == 2'd0);
  assign acc_item  = in_valid && in_ready;
  assign is_read   = (fcmd == {5'd0, cfg.read_code});
  assign take_data = !is_read && (idx < flen);
  assign hdr_ok    = (phase == PH_HEADER) && (fcmd >= 8'd1) && (fcmd <= 8'd4)
                     && (in_byte <= 8'(MAX_DATA_LEN));
  assign el_inc    = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign timed_out = (el_inc >= cfg.timeout);
  assign fd_byte   = fdata[fd_idx[DAW-1:0]];

  // Next receive phase
  always_comb begin
    phase_next = phase;
    if (acc_item) begin
      unique case (in_mode)
        MODE_RX: begin
          unique case (phase)
            PH_HUNT: begin
              if (in_byte == cfg.hdr_first) phase_next = PH_HEADER;
            end
            PH_HEADER, PH_BADHDR: begin
              if (idx == 6'd1) begin
                if (in_byte != cfg.hdr_second) phase_next = PH_BADHDR;
              end else if (idx >= 6'd4) begin
                phase_next = hdr_ok ? PH_BODY : PH_HUNT;
              end
            end
            PH_BODY: begin
              if (!take_data) phase_next = PH_HUNT;
            end
            default: phase_next = phase;
          endcase
        end
        MODE_TICK: begin
          if (phase != PH_HUNT && timed_out) phase_next = PH_HUNT;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Index and queue outputs
  always_comb begin
    idx_next = idx;
    q_push   = 1'b0;
    push_pkt = 1'b0;
    q_din    = '{op: OP_REG, addr: in_addr, len: flen, value: in_value, acc: in_acc};
    if (acc_item) begin
      unique case (in_mode)
        MODE_RX: begin
          unique case (phase)
            PH_HUNT: begin
              if (in_byte == cfg.hdr_first) idx_next = 6'd1;
            end
            PH_HEADER, PH_BADHDR: begin
              idx_next = (idx >= 6'd4) ? 6'd0 : idx + 6'd1;
            end
            PH_BODY: begin
              if (take_data) begin
                idx_next = idx + 6'd1;
              end else begin
                idx_next = 6'd0;
                q_din.addr = faddr;
                if (fsum == in_byte) begin
                  if (is_read) begin
                    q_din.op = OP_PKT_R;
                    q_push   = 1'b1;
                    push_pkt = 1'b1;
                  end else if (fcmd == {5'd0, cfg.write_code}) begin
                    q_din.op = OP_PKT_W;
                    q_push   = 1'b1;
                    push_pkt = 1'b1;
                  end
                end
              end
            end
            default: idx_next = idx;
          endcase
        end
        MODE_TICK: begin
          if (phase != PH_HUNT && timed_out) idx_next = 6'd0;
        end
        MODE_REG: begin q_din.op = OP_REG; q_push = 1'b1; end
        MODE_REM: begin q_din.op = OP_REM; q_push = 1'b1; end
        MODE_RD:  begin q_din.op = OP_RD;  q_push = 1'b1; end
        MODE_WR:  begin q_din.op = OP_WR;  q_push = 1'b1; end
        default:  idx_next = idx;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      idx     <= '0;
      elapsed <= '0;
      pkt_cnt <= 2'd0;
    end else begin
      phase   <= phase_next;
      idx     <= idx_next;
      pkt_cnt <= pkt_cnt + {1'b0, push_pkt} - {1'b0, bstat.pkt_done};
      if (acc_item && in_mode == MODE_RX && phase == PH_HUNT
          && in_byte == cfg.hdr_first) begin
        elapsed <= '0;
      end else if (acc_item && in_mode == MODE_TICK && phase != PH_HUNT) begin
        elapsed <= el_inc;
      end
    end
  end

  // Frame fields, running checksum and data buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      fcmd  <= '0;
      faddr <= '0;
      flen  <= '0;
      fsum  <= '0;
    end else if (acc_item && in_mode == MODE_RX) begin
      if (phase == PH_HEADER || phase == PH_BADHDR) begin
        if (idx == 6'd2) fcmd <= in_byte;
        if (idx == 6'd3) faddr <= in_byte;
        if (idx >= 6'd4 && hdr_ok) begin
          flen <= in_byte[LEN_W-1:0];
          fsum <= fcmd ^ faddr ^ in_byte;
        end
      end else if (phase == PH_BODY && take_data) begin
        fsum <= fsum ^ in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_item && in_mode == MODE_RX && phase == PH_BODY && take_data) begin
      fdata[idx[DAW-1:0]] <= in_byte;
    end
  end
endmodule
`default_nettype wire

// File: rtl/srmb_back.sv
// ----------------------------------------------------------------------------
// srmb_back: map executor and reply generator
// Runs queued operations against the entry map and emits result words.
// ----------------------------------------------------------------------------
`default_nettype none
module srmb_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire srmb_pkg::cfg_t             cfg,
  input  wire srmb_pkg::op_entry_t        q_dout,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output srmb_pkg::back_stat_t            bstat,
  output logic [srmb_pkg::LEN_W-1:0]      fd_idx,
  input  wire logic [7:0]                 fd_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic                            out_ok,
  output logic                            out_last
);
  import srmb_pkg::*;

  bstate_t          state, state_next;
  op_entry_t        cur;
  logic [LEN_W-1:0] idx;
  logic [7:0]       rsum;
  logic [MAP_DEPTH-1:0] fv;
  logic             fvq;
  logic [7:0]       raddr, waddr, eaddr;
  logic [2:0]       fl_rd, fl;
  logic [7:0]       val_rd, val;
  logic             ob_free;
  logic             f_we, v_we, fv_set, fv_clr;
  logic [2:0]       f_wdata;
  logic [7:0]       v_wdata;
  logic             ob_load, ob_kind, ob_ok, ob_last;
  logic [7:0]       ob_byte, hdr_byte;
  logic             idx_inc, idx_clr, rsum_ld, rsum_x;

  // A readable entry has always been registered, so its value is written
  assign ob_free = !out_valid || out_ready;
  assign eaddr   = cur.addr + {2'b00, idx};
  assign fl      = fvq ? fl_rd : 3'd0;
  assign val     = val_rd;
  assign fd_idx  = idx;
  assign waddr   = (state == B_LEXE) ? cur.addr : eaddr;

  always_comb begin
    unique case (state)
      B_IDLE:  raddr = q_dout.addr;
      B_LEXE:  raddr = cur.addr;
      default: raddr = eaddr;
    endcase
  end

  always_comb begin
    unique case (idx[2:0])
      3'd0:    hdr_byte = cfg.hdr_first;
      3'd1:    hdr_byte = cfg.hdr_second;
      3'd2:    hdr_byte = {5'd0, cfg.ret_code};
      3'd3:    hdr_byte = cur.addr;
      default: hdr_byte = {2'b00, cur.len};
    endcase
  end

  srmb_ram #(.WIDTH(3), .DEPTH(MAP_DEPTH)) u_flags (
    .clk(clk), .we(f_we), .waddr(waddr), .wdata(f_wdata), .raddr(raddr), .rdata(fl_rd)
  );
  srmb_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_values (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wdata), .raddr(raddr), .rdata(val_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_dout.op)
            OP_PKT_R: state_next = B_HDR;
            OP_PKT_W: state_next = (q_dout.len == '0) ? B_IDLE : B_WRD;
            default:  state_next = B_LEXE;
          endcase
        end
      end
      B_LEXE: if (ob_free) state_next = B_IDLE;
      B_HDR: begin
        if (ob_free && idx == 6'd4) state_next = (cur.len == '0) ? B_SUM : B_DRD;
      end
      B_DRD: state_next = B_DOUT;
      B_DOUT: begin
        if (ob_free) state_next = (idx + 6'd1 == cur.len) ? B_SUM : B_DRD;
      end
      B_SUM: if (ob_free) state_next = B_IDLE;
      B_WRD: state_next = B_WEXE;
      B_WEXE: state_next = (idx + 6'd1 == cur.len) ? B_IDLE : B_WRD;
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of each state
  always_comb begin
    q_pop = 1'b0; bstat.pkt_done = 1'b0;
    f_we = 1'b0; v_we = 1'b0; f_wdata = 3'd0; v_wdata = cur.value;
    fv_set = 1'b0; fv_clr = 1'b0;
    ob_load = 1'b0; ob_kind = 1'b1; ob_byte = 8'd0; ob_ok = 1'b0; ob_last = 1'b1;
    idx_inc = 1'b0; idx_clr = 1'b0; rsum_ld = 1'b0; rsum_x = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_pop   = !q_empty;
        idx_clr = 1'b1;
        if (!q_empty && q_dout.op == OP_PKT_W && q_dout.len == '0) bstat.pkt_done = 1'b1;
      end
      B_LEXE: begin
        if (ob_free) begin
          ob_load = 1'b1;
          unique case (cur.op)
            OP_REG: begin
              if (!fl[2]) begin
                f_we = 1'b1; f_wdata = {1'b1, cur.acc}; fv_set = 1'b1;
                v_we = 1'b1; ob_ok = 1'b1;
              end
            end
            OP_REM: begin fv_clr = 1'b1; ob_ok = 1'b1; end
            OP_RD: begin
              if (fl[0]) begin ob_byte = val; ob_ok = 1'b1; end
            end
            OP_WR: begin
              if (fl[1]) begin v_we = 1'b1; ob_ok = 1'b1; end
            end
            default: ob_load = 1'b1;
          endcase
        end
      end
      B_HDR: begin
        if (ob_free) begin
          ob_load = 1'b1; ob_kind = 1'b0; ob_last = 1'b0; ob_byte = hdr_byte;
          if (idx == 6'd4) begin idx_clr = 1'b1; rsum_ld = 1'b1; end
          else idx_inc = 1'b1;
        end
      end
      B_DOUT: begin
        if (ob_free) begin
          ob_load = 1'b1; ob_kind = 1'b0; ob_last = 1'b0;
          ob_byte = fl[0] ? val : 8'd0;
          rsum_x  = 1'b1; idx_inc = 1'b1;
        end
      end
      B_SUM: begin
        if (ob_free) begin
          ob_load = 1'b1; ob_kind = 1'b0; ob_byte = rsum;
          bstat.pkt_done = 1'b1;
        end
      end
      B_WEXE: begin
        v_wdata = fd_byte;
        if (fl[1]) v_we = 1'b1;
        idx_inc = 1'b1;
        if (idx + 6'd1 == cur.len) bstat.pkt_done = 1'b1;
      end
      default: idx_inc = 1'b0;
    endcase
  end

  // Control registers and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      fv        <= '0;
    end else begin
      state <= state_next;
      if (ob_load)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fv_set) fv[waddr] <= 1'b1;
      if (fv_clr) fv[waddr] <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fvq <= fv[raddr];
    if (q_pop) cur <= q_dout;
    if (idx_clr)      idx <= '0;
    else if (idx_inc) idx <= idx + 6'd1;
    if (rsum_ld)     rsum <= {5'd0, cfg.ret_code} ^ cur.addr ^ {2'b00, cur.len};
    else if (rsum_x) rsum <= rsum ^ (fl[0] ? val : 8'd0);
    if (ob_load) begin
      out_kind <= ob_kind;
      out_byte <= ob_byte;
      out_ok   <= ob_ok;
      out_last <= ob_last;
    end
  end

`ifndef SYNTH
  a_local_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind |-> out_last) else $error("local answer without last");
  a_dout_idx: assert property (@(posedge clk) disable iff (rst)
    state == B_DOUT |-> idx < cur.len) else $error("reply index past length");
  a_sum_end: assert property (@(posedge clk) disable iff (rst)
    state == B_SUM && ob_free |=> state == B_IDLE) else $error("reply did not end");
`endif
endmodule
`default_nettype wire

// File: rtl/serial_register_map_bridge.sv
// ----------------------------------------------------------------------------
// serial_register_map_bridge: serial framed access to a 256-entry byte map
// Front framer feeds a two-word operation queue; back end runs the map.
//
//   port group   dir   words
//   s_*          in    input items (mode in tuser)
//   m_*          out   reply bytes and local answers
//   cfg_*        in    register writes, always ready
//
// A local operation passes through B_IDLE and B_LEXE in the back. A read packet
// sends five header bytes, reads and sends each data byte, then the checksum;
// a write packet reads and writes each data byte, as the map memories have a
// single read port. While a packet operation is queued or running, input
// stalls. Reset clears control state and the map valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module serial_register_map_bridge #(
  parameter int unsigned MAX_DATA_LEN = srmb_pkg::MAX_DATA_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // rx_byte, entry_address, entry_access, entry_value
  input  wire logic [2:0]  s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte, ok
  output logic             m_tuser,   // kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import srmb_pkg::*;

  cfg_t       cfg;
  op_entry_t  q_din, q_dout;
  logic       q_push, q_pop, q_empty, q_full;
  back_stat_t bstat;
  logic [LEN_W-1:0] fd_idx;
  logic [7:0] fd_byte, ob_byte;
  logic       ob_ok;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, ob_ok, ob_byte};

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{hdr_first: 8'd170, hdr_second: 8'd85, read_code: 3'd1,
               ret_code: 3'd2, write_code: 3'd3, timeout: 16'd100};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HDR_FIRST:  cfg.hdr_first  <= cfg_data[7:0];
        CFG_HDR_SECOND: cfg.hdr_second <= cfg_data[7:0];
        CFG_READ_CODE:  cfg.read_code  <= cfg_data[2:0];
        CFG_RET_CODE:   cfg.ret_code   <= cfg_data[2:0];
        CFG_WRITE_CODE: cfg.write_code <= cfg_data[2:0];
        CFG_TIMEOUT:    cfg.timeout    <= cfg_data;
        default:        cfg.timeout    <= cfg.timeout;
      endcase
    end
  end

  srmb_front #(.MAX_DATA_LEN(MAX_DATA_LEN)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_mode(s_tuser),
    .in_byte(s_tdata[7:0]), .in_addr(s_tdata[15:8]), .in_acc(s_tdata[17:16]),
    .in_value(s_tdata[25:18]),
    .q_push(q_push), .q_din(q_din), .q_full(q_full), .bstat(bstat),
    .fd_idx(fd_idx), .fd_byte(fd_byte)
  );

  srmb_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .pop(q_pop),
    .dout(q_dout), .empty(q_empty), .full(q_full)
  );

  srmb_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_dout(q_dout), .q_empty(q_empty), .q_pop(q_pop), .bstat(bstat),
    .fd_idx(fd_idx), .fd_byte(fd_byte),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser),
    .out_byte(ob_byte), .out_ok(ob_ok), .out_last(m_tlast)
  );
endmodule
`default_nettype wire
